### rtl/core/ulebdfr_pkg.sv
// ---------------------------------------------------------------------------
// ulebdfr_pkg - shared types and constants of the LEB128 frame deframer
// Phase codes, length-decoder widths and the structs between the modules.
// ---------------------------------------------------------------------------
package ulebdfr_pkg;

	// Longest length field before it counts as overflowed, in bytes.
	localparam int MAX_LENGTH_BYTES = 5;
	// Checksum bytes at the end of each frame, most significant first.
	localparam int CHECKSUM_BYTES   = 4;

	localparam int LEN_CNT_W  = $clog2(MAX_LENGTH_BYTES + 1);
	localparam int CSUM_CNT_W = $clog2(CHECKSUM_BYTES + 1);
	localparam int SHIFT_W    = 6;
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = '1;
	localparam int LEB_GROUP_W = 7;
	localparam logic [SHIFT_W-1:0] SHIFT_STEP = SHIFT_W'(LEB_GROUP_W);
	// Wide enough for a 7-bit group shifted by up to 31.
	localparam int LEB_WIDE_W = 32 + LEB_GROUP_W;
	localparam int CONT_BIT   = 7;

	// Phase of the parser; a byte's role is the phase it arrives in.
	typedef enum logic [2:0] {
		PH_VERSION  = 3'd0,
		PH_COMMAND  = 3'd1,
		PH_LENGTH   = 3'd2,
		PH_PAYLOAD  = 3'd3,
		PH_CHECKSUM = 3'd4
	} phase_t;

	// Length decoder state after one length byte.
	typedef struct packed {
		logic [31:0]            accum;
		logic [SHIFT_W-1:0]     shift;
		logic [LEN_CNT_W-1:0]   count;
		logic                   overflow;
		logic                   last;
	} len_next_t;

	// Everything reported for one input byte.
	typedef struct packed {
		phase_t      role;
		logic [7:0]  data;
		logic [7:0]  version;
		logic [7:0]  command;
		logic [31:0] length;
		logic        length_done;
		logic        overflow;
		logic [31:0] checksum;
		logic        frame_end;
	} result_t;

endpackage

### rtl/core/ulebdfr_len_step.sv
// ---------------------------------------------------------------------------
// ulebdfr_len_step - one LEB128 length byte
// Merges a 7-bit group into the length, tracks overflow and counters.
// ---------------------------------------------------------------------------
module ulebdfr_len_step (
	input  logic [7:0]                         data,
	input  logic [31:0]                        accum,
	input  logic [ulebdfr_pkg::SHIFT_W-1:0]    shift,
	input  logic [ulebdfr_pkg::LEN_CNT_W-1:0]  count,
	input  logic                               overflow,
	output ulebdfr_pkg::len_next_t             nxt
);

	logic [ulebdfr_pkg::LEB_GROUP_W-1:0] grp;
	logic [ulebdfr_pkg::LEB_WIDE_W-1:0]  wide;
	logic [31:0]                         placed;
	logic                                ovf_grp;
	logic                                ovf_cnt;
	logic                                ovf_all;
	logic [ulebdfr_pkg::SHIFT_W:0]       shift_sum;

	assign grp = data[ulebdfr_pkg::LEB_GROUP_W-1:0];

	always_comb begin
		wide = {{(ulebdfr_pkg::LEB_WIDE_W - ulebdfr_pkg::LEB_GROUP_W){1'b0}}, grp}
			<< shift[4:0];
		// Group lands entirely at bit 32 or above once the shift reaches 32.
		if (shift[5]) begin
			placed  = '0;
			ovf_grp = (grp != '0);
		end else begin
			placed  = wide[31:0];
			ovf_grp = |wide[ulebdfr_pkg::LEB_WIDE_W-1:32];
		end
		ovf_cnt = (count >= ulebdfr_pkg::LEN_CNT_W'(ulebdfr_pkg::MAX_LENGTH_BYTES));
		ovf_all = overflow | ovf_cnt | ovf_grp;

		shift_sum = {1'b0, shift} + {1'b0, ulebdfr_pkg::SHIFT_STEP};

		nxt.accum    = ovf_all ? '1 : (accum | placed);
		nxt.overflow = ovf_all;
		nxt.shift    = shift_sum[ulebdfr_pkg::SHIFT_W] ? ulebdfr_pkg::SHIFT_MAX
			: shift_sum[ulebdfr_pkg::SHIFT_W-1:0];
		nxt.count    = ovf_cnt ? count : count + 1'b1;
		nxt.last     = ~data[ulebdfr_pkg::CONT_BIT];
	end

endmodule

### rtl/core/ulebdfr_parser.sv
// ---------------------------------------------------------------------------
// ulebdfr_parser - frame phase machine and frame field registers
// Classifies each byte and updates the frame state when it is taken.
// ---------------------------------------------------------------------------
module ulebdfr_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           data,
	output ulebdfr_pkg::result_t res
);

	ulebdfr_pkg::phase_t                 phase_q, phase_nxt;
	logic [7:0]                          version_q, version_nxt;
	logic [7:0]                          command_q, command_nxt;
	logic [31:0]                         len_q, len_nxt;
	logic [ulebdfr_pkg::SHIFT_W-1:0]     shift_q, shift_nxt;
	logic [ulebdfr_pkg::LEN_CNT_W-1:0]   lcnt_q, lcnt_nxt;
	logic                                ovf_q, ovf_nxt;
	logic [31:0]                         remain_q, remain_nxt;
	logic [31:0]                         remain_dec;
	logic [31:0]                         csum_q, csum_nxt;
	logic [ulebdfr_pkg::CSUM_CNT_W-1:0]  ccnt_q, ccnt_nxt;
	ulebdfr_pkg::len_next_t              len_step;

	ulebdfr_len_step u_len (
		.data     (data),
		.accum    (len_q),
		.shift    (shift_q),
		.count    (lcnt_q),
		.overflow (ovf_q),
		.nxt      (len_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ulebdfr_pkg::PH_VERSION;
			version_q <= '0;
			command_q <= '0;
			len_q     <= '0;
			shift_q   <= '0;
			lcnt_q    <= '0;
			ovf_q     <= 1'b0;
			remain_q  <= '0;
			csum_q    <= '0;
			ccnt_q    <= '0;
		end else if (advance) begin
			phase_q   <= phase_nxt;
			version_q <= version_nxt;
			command_q <= command_nxt;
			len_q     <= len_nxt;
			shift_q   <= shift_nxt;
			lcnt_q    <= lcnt_nxt;
			ovf_q     <= ovf_nxt;
			remain_q  <= remain_nxt;
			csum_q    <= csum_nxt;
			ccnt_q    <= ccnt_nxt;
		end
	end

	assign remain_dec = remain_q - {31'd0, (remain_q != '0)};

	always_comb begin
		phase_nxt   = phase_q;
		version_nxt = version_q;
		command_nxt = command_q;
		len_nxt     = len_q;
		shift_nxt   = shift_q;
		lcnt_nxt    = lcnt_q;
		ovf_nxt     = ovf_q;
		remain_nxt  = remain_q;
		csum_nxt    = csum_q;
		ccnt_nxt    = ccnt_q;
		res.role        = phase_q;
		res.length_done = 1'b0;
		res.frame_end   = 1'b0;

		case (phase_q)
			ulebdfr_pkg::PH_COMMAND: begin
				command_nxt = data;
				phase_nxt   = ulebdfr_pkg::PH_LENGTH;
			end
			ulebdfr_pkg::PH_LENGTH: begin
				len_nxt   = len_step.accum;
				shift_nxt = len_step.shift;
				lcnt_nxt  = len_step.count;
				ovf_nxt   = len_step.overflow;
				if (len_step.last) begin
					res.length_done = 1'b1;
					remain_nxt      = len_step.accum;
					phase_nxt       = (len_step.accum == '0) ? ulebdfr_pkg::PH_CHECKSUM
						: ulebdfr_pkg::PH_PAYLOAD;
				end
			end
			ulebdfr_pkg::PH_PAYLOAD: begin
				res.length_done = 1'b1;
				remain_nxt      = remain_dec;
				if (remain_dec == '0) begin
					phase_nxt = ulebdfr_pkg::PH_CHECKSUM;
				end
			end
			ulebdfr_pkg::PH_CHECKSUM: begin
				res.length_done = 1'b1;
				csum_nxt        = {csum_q[23:0], data};
				ccnt_nxt        = ccnt_q + 1'b1;
				if (ccnt_nxt >= ulebdfr_pkg::CSUM_CNT_W'(ulebdfr_pkg::CHECKSUM_BYTES)) begin
					res.frame_end = 1'b1;
					phase_nxt     = ulebdfr_pkg::PH_VERSION;
				end
			end
			default: begin
				// Version byte: start a fresh frame.
				res.role    = ulebdfr_pkg::PH_VERSION;
				version_nxt = data;
				command_nxt = '0;
				len_nxt     = '0;
				shift_nxt   = '0;
				lcnt_nxt    = '0;
				ovf_nxt     = 1'b0;
				remain_nxt  = '0;
				csum_nxt    = '0;
				ccnt_nxt    = '0;
				phase_nxt   = ulebdfr_pkg::PH_COMMAND;
			end
		endcase

		res.data     = data;
		res.version  = version_nxt;
		res.command  = command_nxt;
		res.length   = len_nxt;
		res.overflow = ovf_nxt;
		res.checksum = csum_nxt;
	end

endmodule

### rtl/core/uleb128_length_prefixed_deframer.sv
// ---------------------------------------------------------------------------
// uleb128_length_prefixed_deframer - byte-stream deframer for LEB128 frames
// Tags each byte of version/command/length/payload/checksum frames and
// reports the frame fields known after that byte.
// ---------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid, in_stall   | data_byte
//  output   | out_valid, out_stall | byte_role, data_out, frame_version,
//           |                      | frame_command, payload_length, length_done,
//           |                      | length_overflow, frame_checksum, frame_end
//
//  One byte per cycle sustained while out_stall is low; each input transaction
//  yields exactly one output transaction via the input and output registers.
//  The frame state updates in one pass from the input register to the output
//  register, so back-to-back bytes never wait on each other.
//  arst_n clears both valid flags and returns the parser to the version phase.
//  out_stall holds the output register; the input register keeps taking
//  bytes until it is full behind a stalled output.
//
module uleb128_length_prefixed_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  byte_role,
	output logic [7:0]  data_out,
	output logic [7:0]  frame_version,
	output logic [7:0]  frame_command,
	output logic [31:0] payload_length,
	output logic        length_done,
	output logic        length_overflow,
	output logic [31:0] frame_checksum,
	output logic        frame_end
);

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 valid_s2;
	ulebdfr_pkg::result_t res_s2;
	ulebdfr_pkg::result_t res;
	logic                 advance;

	// Move the held byte on whenever the output register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register: take a new transaction unless it must hold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
		end
	end

	// Classify the byte and update the frame state as it advances.
	ulebdfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.data    (data_s1),
		.res     (res)
	);

	// Output register: load on advance, drop once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign byte_role       = res_s2.role;
	assign data_out        = res_s2.data;
	assign frame_version   = res_s2.version;
	assign frame_command   = res_s2.command;
	assign payload_length  = res_s2.length;
	assign length_done     = res_s2.length_done;
	assign length_overflow = res_s2.overflow;
	assign frame_checksum  = res_s2.checksum;
	assign frame_end       = res_s2.frame_end;

	// The input side only stalls behind a full, stalled output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a stalled output");

	// The frame end marks a checksum byte.
	a_end_role: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> (byte_role == ulebdfr_pkg::PH_CHECKSUM))
		else $error("frame end on a non-checksum byte");

	// An overflowed length is saturated.
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && length_overflow) |-> (payload_length == 32'hFFFF_FFFF))
		else $error("overflowed length not saturated");

	// A payload byte follows a fully decoded length.
	a_payload_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_role == ulebdfr_pkg::PH_PAYLOAD) |-> length_done)
		else $error("payload byte before length decoded");

endmodule

### tb/sv/uleb128_deframer_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uleb128_deframer_check - frame report predictor and comparator
// Watches both channels of the deframer. Every input transaction is run
// through a local copy of the frame parser. Every output transaction is
// compared field by field with the oldest predicted report.
// ---------------------------------------------------------------------------
module uleb128_deframer_check
	import ulebdfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  byte_role,
	input  logic [7:0]  data_out,
	input  logic [7:0]  frame_version,
	input  logic [7:0]  frame_command,
	input  logic [31:0] payload_length,
	input  logic        length_done,
	input  logic        length_overflow,
	input  logic [31:0] frame_checksum,
	input  logic        frame_end,
	output int          mismatch_count,
	output int          reports_outstanding
);

	// Parser state, mirrored from the stream
	phase_t      cur_phase  = PH_VERSION;
	logic [7:0]  version    = '0;
	logic [7:0]  command    = '0;
	logic [31:0] len_value  = '0;
	int          len_shift  = 0;
	int          len_bytes  = 0;
	logic        len_ovf    = 1'b0;
	logic [31:0] bytes_left = '0;
	logic [31:0] csum       = '0;
	int          csum_bytes = 0;

	result_t awaited_reports[$];
	int      fails        = 0;
	int      results_seen = 0;

	task automatic clear_frame();
		command    = '0;
		len_value  = '0;
		len_shift  = 0;
		len_bytes  = 0;
		len_ovf    = 1'b0;
		bytes_left = '0;
		csum       = '0;
		csum_bytes = 0;
	endtask

	// Advance the parser by one byte and build the report it causes.
	task automatic parse_byte(input logic [7:0] b, output result_t r);
		logic [6:0]  grp;
		logic [63:0] wide;
		r      = '0;
		r.role = cur_phase;
		r.data = b;
		case (cur_phase)
			PH_COMMAND: begin
				command   = b;
				cur_phase = PH_LENGTH;
			end
			PH_LENGTH: begin
				grp = b[6:0];
				if (len_bytes >= MAX_LENGTH_BYTES)
					len_ovf = 1'b1;
				if (len_shift >= 32) begin
					if (grp != '0)
						len_ovf = 1'b1;
				end else begin
					wide = 64'(grp) << len_shift;
					if (wide[63:32] != '0)
						len_ovf = 1'b1;
					len_value = len_value | wide[31:0];
				end
				if (len_ovf)
					len_value = '1;
				len_shift = (len_shift + 7 > 63) ? 63 : len_shift + 7;
				if (len_bytes < MAX_LENGTH_BYTES)
					len_bytes++;
				if (!b[7]) begin
					r.length_done = 1'b1;
					bytes_left    = len_value;
					cur_phase     = (len_value == '0) ? PH_CHECKSUM : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				r.length_done = 1'b1;
				if (bytes_left != '0)
					bytes_left--;
				if (bytes_left == '0)
					cur_phase = PH_CHECKSUM;
			end
			PH_CHECKSUM: begin
				r.length_done = 1'b1;
				csum = {csum[23:0], b};
				csum_bytes++;
				if (csum_bytes >= CHECKSUM_BYTES) begin
					r.frame_end = 1'b1;
					cur_phase   = PH_VERSION;
				end
			end
			default: begin
				clear_frame();
				version   = b;
				cur_phase = PH_COMMAND;
			end
		endcase
		r.version  = version;
		r.command  = command;
		r.length   = len_value;
		r.overflow = len_ovf;
		r.checksum = csum;
	endtask

	function automatic bit same_field(input string name, input logic [31:0] want,
			input logic [31:0] seen, input bit report);
		if (want === seen)
			return 1'b1;
		if (report)
			$display("result %0d: %s expected %0h got %0h", results_seen, name, want, seen);
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t fresh;
		bit      ok;
		bit      report;
		if (!arst_n) begin
			cur_phase = PH_VERSION;
			version   = '0;
			clear_frame();
			awaited_reports.delete();
		end else begin
			if (in_valid && !in_stall) begin
				parse_byte(data_byte, fresh);
				awaited_reports.push_back(fresh);
			end
			if (out_valid && !out_stall) begin
				report = (fails < 10);
				if (awaited_reports.size() == 0) begin
					if (report)
						$display("result %0d: no report awaited, role %0d data %0h",
							results_seen, byte_role, data_out);
					fails++;
				end else begin
					want = awaited_reports.pop_front();
					ok = 1'b1;
					ok &= same_field("byte_role", 32'(want.role), 32'(byte_role), report);
					ok &= same_field("data_out", 32'(want.data), 32'(data_out), report);
					ok &= same_field("frame_version", 32'(want.version), 32'(frame_version),
						report);
					ok &= same_field("frame_command", 32'(want.command), 32'(frame_command),
						report);
					ok &= same_field("payload_length", want.length, payload_length, report);
					ok &= same_field("length_done", 32'(want.length_done), 32'(length_done),
						report);
					ok &= same_field("length_overflow", 32'(want.overflow),
						32'(length_overflow), report);
					ok &= same_field("frame_checksum", want.checksum, frame_checksum, report);
					ok &= same_field("frame_end", 32'(want.frame_end), 32'(frame_end), report);
					if (!ok)
						fails++;
				end
				results_seen++;
			end
		end
		mismatch_count      <= fails;
		reports_outstanding <= awaited_reports.size();
	end

endmodule

### tb/sv/tb_uleb128_length_prefixed_deframer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_uleb128_length_prefixed_deframer - stream test of the LEB128 deframer
// Feeds a byte stream of back-to-back frames (directed corner frames, then
// random frames, then one frame whose length overflows) under random stalls
// on both channels, and reports the verdict of the side-by-side checker.
// ---------------------------------------------------------------------------
module tb_uleb128_length_prefixed_deframer;
	import ulebdfr_pkg::*;

	// Random part of the stream, in bytes
	localparam int RANDOM_ITEMS = 1200;
	// Receiver hold-off long enough to back the block up into its input
	localparam int LONG_HOLD    = 60;
	// Generous bound on the whole run
	localparam int TIMEOUT_NS   = 2_000_000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [2:0]  byte_role;
	logic [7:0]  data_out;
	logic [7:0]  frame_version;
	logic [7:0]  frame_command;
	logic [31:0] payload_length;
	logic        length_done;
	logic        length_overflow;
	logic [31:0] frame_checksum;
	logic        frame_end;

	int mismatch_count;
	int reports_outstanding;

	// Handshake between the sender and the receiver process; both are
	// written with nonblocking assignments so the receiver reads them
	// free of any ordering within the step.
	logic stall_free    = 1'b0;
	logic long_hold_req = 1'b0;

	logic [7:0] frame_bytes[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hold reset low from the start, then release it at a rising edge
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	uleb128_length_prefixed_deframer u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.byte_role       (byte_role),
		.data_out        (data_out),
		.frame_version   (frame_version),
		.frame_command   (frame_command),
		.payload_length  (payload_length),
		.length_done     (length_done),
		.length_overflow (length_overflow),
		.frame_checksum  (frame_checksum),
		.frame_end       (frame_end)
	);

	uleb128_deframer_check u_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.data_byte           (data_byte),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.byte_role           (byte_role),
		.data_out            (data_out),
		.frame_version       (frame_version),
		.frame_command       (frame_command),
		.payload_length      (payload_length),
		.length_done         (length_done),
		.length_overflow     (length_overflow),
		.frame_checksum      (frame_checksum),
		.frame_end           (frame_end),
		.mismatch_count      (mismatch_count),
		.reports_outstanding (reports_outstanding)
	);

	// Append one well-formed frame. The length goes out as minimal LEB128,
	// then pad extra bytes (continuation groups of zero and a closing 0x00)
	// stretch it to a non-minimal encoding. Payload and checksum bytes take
	// the value fill, or random values when fill is negative.
	task automatic add_frame(input logic [7:0] ver, input logic [7:0] cmd, input int len,
			input int pad, input int fill);
		int         rest;
		int         k;
		logic [7:0] grp;
		frame_bytes.push_back(ver);
		frame_bytes.push_back(cmd);
		rest = len;
		do begin
			grp  = 8'(rest & 'h7F);
			rest = rest >> 7;
			if (rest != 0 || pad != 0)
				grp[7] = 1'b1;
			frame_bytes.push_back(grp);
		end while (rest != 0);
		for (k = 1; k < pad; k++)
			frame_bytes.push_back(8'h80);
		if (pad != 0)
			frame_bytes.push_back(8'h00);
		repeat (len + CHECKSUM_BYTES)
			frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
	endtask

	// Sender: build the stream, then offer it one transaction at a time
	initial begin : sender
		int idx;
		int len;
		int pad;
		int pick;
		int pause_at;
		int hold_at;
		int quiet_from;

		// Directed frames: all-zero frame with a zero length that skips the
		// payload, all-ones frame with a one-byte payload, and a zero length
		// in a two-byte non-minimal encoding.
		add_frame(8'h00, 8'h00, 0, 0, 0);
		add_frame(8'hFF, 8'hFF, 1, 0, 'hFF);
		add_frame(8'h5A, 8'hA5, 0, 1, -1);

		// Random frames: mostly short payloads, a few two-byte lengths, and
		// now and then a length padded out to as many as five bytes.
		pause_at = 0;
		hold_at  = 0;
		while (frame_bytes.size() < 24 + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 2)
				len = 0;
			else if (pick < 14)
				len = $urandom_range(1, 16);
			else if (pick < 19)
				len = $urandom_range(17, 48);
			else
				len = $urandom_range(120, 300);
			pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, (len < 128) ? 4 : 3) : 0;
			add_frame(8'($urandom), 8'($urandom), len, pad, -1);
			if (pause_at == 0 && frame_bytes.size() > 450)
				pause_at = frame_bytes.size();
			if (hold_at == 0 && frame_bytes.size() > 850)
				hold_at = frame_bytes.size();
		end
		quiet_from = frame_bytes.size() - 60;

		// Closing frame: an overflowing length never gets through its
		// payload, so it must come last. Either reach the widest length that
		// still fits in five bytes and overflow on the byte count, or push
		// data bits past bit 31 on the fifth byte. Keep the field running
		// long enough to saturate the shift, then take a few payload bytes.
		frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back(8'($urandom));
		repeat (4)
			frame_bytes.push_back(8'hFF);
		frame_bytes.push_back($urandom_range(0, 1) ? 8'h8F : 8'hFF);
		repeat (7)
			frame_bytes.push_back(8'h80 | 8'($urandom));
		frame_bytes.push_back(8'($urandom_range(0, 127)));
		repeat (20)
			frame_bytes.push_back(8'($urandom));

		while (!arst_n)
			@(posedge clk);

		for (idx = 0; idx < frame_bytes.size(); idx++) begin
			if (idx == quiet_from)
				stall_free <= 1'b1;
			if (idx == hold_at)
				long_hold_req <= 1'b1;
			if (idx == pause_at) begin
				// Drain: hold off until every report has come back
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (reports_outstanding != 0);
			end else if (idx < quiet_from && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 3))
					@(posedge clk);
			end
			in_valid  <= 1'b1;
			data_byte <= frame_bytes[idx];
			// Hold the transaction until the block takes it
			do
				@(posedge clk);
			while (in_stall);
		end
		in_valid <= 1'b0;

		do
			@(posedge clk);
		while (reports_outstanding != 0);
		// Two register stages; give stray results time to show up
		repeat (8)
			@(posedge clk);

		if (mismatch_count == 0 && reports_outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Receiver: short random stall bursts, one long hold-off on request,
	// and no stalls once the sender reaches the last stretch.
	initial begin : receiver
		bit long_hold_done;
		long_hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD)
					@(posedge clk);
				out_stall <= 1'b0;
			end else if (!stall_free && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3))
					@(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Bound the run in case a handshake never completes
	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule
